/* src/ibu_pkg.sv */
// ----------------------------------------------------------------------------
// ibu_pkg
// Types, widths and constants shared by the Bayesian unfolder.
// ----------------------------------------------------------------------------
package ibu_pkg;

  localparam int NUM_BINS   = 1024;
  localparam int ADDR_W     = $clog2(NUM_BINS);
  localparam int BIN_W      = 10;
  localparam int RINGS      = 4;
  localparam int RESP_W     = 16;
  localparam int EFF_W      = 18;
  localparam int PROB_W     = 25;
  localparam int CNT_W      = 32;
  localparam int MEAS_W     = 32;
  localparam int ITER_W     = 20;
  localparam int NUM_W      = RESP_W + PROB_W;
  localparam int SUM_W      = 48;
  localparam int PROD_W     = MEAS_W + PROB_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int TOT_W      = CNT_W + ADDR_W;
  localparam int DIV_W      = 48;
  localparam int Q_W        = 32;
  localparam int STEP_W     = 6;
  localparam int FRAC_STEPS = 24;
  localparam int CAUSE_STEPS = 32;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
  localparam logic [PROB_W-1:0] ONE_Q24 = PROB_W'(1) << 24;
  localparam logic [PROB_W-1:0] UNIFORM =
    PROB_W'(((1 << 24) + NUM_BINS / 2) / NUM_BINS);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(100001);

  localparam logic [2:0] REG_MEAS1 = 3'd0;
  localparam logic [2:0] REG_MEAS2 = 3'd1;
  localparam logic [2:0] REG_MEAS3 = 3'd2;
  localparam logic [2:0] REG_MEAS4 = 3'd3;
  localparam logic [2:0] REG_ITER  = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic              command;
    logic [BIN_W-1:0]  bin_index;
    logic [RESP_W-1:0] resp_ring1;
    logic [RESP_W-1:0] resp_ring2;
    logic [RESP_W-1:0] resp_ring3;
    logic [RESP_W-1:0] resp_ring4;
    logic              last_load;
  } item_t;

  typedef struct packed {
    logic [BIN_W-1:0]  out_bin;
    logic [CNT_W-1:0]  bin_counts;
    logic [PROB_W-1:0] bin_probability;
  } result_t;

  typedef struct packed {
    logic sum_clr;
    logic sum_add;
    logic div_start;
    logic prod_load;
  } lane_ctl_t;

endpackage

/* src/ibu_ram.sv */
// ----------------------------------------------------------------------------
// ibu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ibu_div.sv */
// ----------------------------------------------------------------------------
// ibu_div
// Restoring divider, one quotient bit per cycle. The caller must start the
// remainder below the divisor (unchecked); dividend bits shift in msb first.
// ----------------------------------------------------------------------------
module ibu_div import ibu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  rem_init,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [Q_W-1:0]    shin,
  input  logic [STEP_W-1:0] steps,
  output logic              done,
  output logic [Q_W-1:0]    quot
);

  logic              run;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dv;
  logic [Q_W-1:0]    sh;
  logic [DIV_W:0]    rem2;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign rem2 = {rem, sh[Q_W-1]};
  assign diff = rem2 - {1'b0, dv};
  assign ge   = rem2 >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= steps;
      end else if (run) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      dv   <= divisor;
      sh   <= shin;
      quot <= '0;
    end else if (run) begin
      rem  <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
      sh   <= {sh[Q_W-2:0], 1'b0};
      quot <= {quot[Q_W-2:0], ge};
    end
  end

endmodule

/* src/ibu_lane.sv */
// ----------------------------------------------------------------------------
// ibu_lane
// One detector ring: forms R*p, accumulates the ring sum, derives the
// Q1.24 weight R*p/S and scales it by the ring's measured count.
// ----------------------------------------------------------------------------
module ibu_lane import ibu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lane_ctl_t         ctl,
  input  logic [RESP_W-1:0] resp,
  input  logic [PROB_W-1:0] prior,
  input  logic [MEAS_W-1:0] meas,
  output logic              div_done,
  output logic [PROD_W-1:0] prod
);

  logic [NUM_W-1:0]  num;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W:0]    sum_wide;
  logic              s_zero;
  logic              s_full;
  logic [Q_W-1:0]    quot;
  logic [PROB_W-1:0] w;

  assign sum_wide = {1'b0, sum} + (SUM_W+1)'(num);

  always_ff @(posedge clk) begin
    num <= resp * prior;
    if (ctl.sum_clr) begin
      sum <= '0;
    end else if (ctl.sum_add) begin
      sum <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end
    if (ctl.div_start) begin
      s_zero <= sum == '0;
      s_full <= SUM_W'(num) >= sum;
    end
    if (ctl.prod_load) begin
      prod <= meas * w;
    end
  end

  always_comb begin
    if (s_zero) begin
      w = '0;
    end else if (s_full) begin
      w = ONE_Q24;
    end else begin
      w = quot[PROB_W-1:0];
    end
  end

  ibu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .rem_init (DIV_W'(num)),
    .divisor  (DIV_W'(sum)),
    .shin     ('0),
    .steps    (STEP_W'(FRAC_STEPS)),
    .done     (div_done),
    .quot     (quot)
  );

endmodule

/* src/iterative_bayesian_unfolder.sv */
// ----------------------------------------------------------------------------
// iterative_bayesian_unfolder
// Richardson-Lucy unfolding of a four-ring detector response.
//
// Items arrive on item/item_valid/item_stall, results leave on
// result/result_valid/result_stall; a beat moves when valid is high and
// stall is low. The user must write measured ring counts and the iteration
// count over the APB port while the block is idle; this is not enforced.
// A load beat writes one bin's responses. A load with last_load set starts
// a run unless the iteration count is zero. Each iteration makes three
// passes over the bins: ring sums, then the four ring dividers in parallel
// plus the cause divider, then the shared normalizing divider; the last two
// passes are bound by the one-bit-per-cycle dividers. No item is taken
// during a run. A read beat goes through states RD_WAIT and RD_OUT before
// its result is registered; the block takes the next item once the result
// register is loaded; a stalled result holds and blocks further reads.
// Reset (rst, synchronous) clears control state; results then read as
// zero counts with a uniform prior.
// ----------------------------------------------------------------------------
module iterative_bayesian_unfolder import ibu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_RD_WAIT = 5'd1;
  localparam logic [4:0] ST_RD_OUT  = 5'd2;
  localparam logic [4:0] ST_INIT    = 5'd3;
  localparam logic [4:0] ST_A_RD    = 5'd4;
  localparam logic [4:0] ST_A_MUL   = 5'd5;
  localparam logic [4:0] ST_A_ADD   = 5'd6;
  localparam logic [4:0] ST_B_RD    = 5'd7;
  localparam logic [4:0] ST_B_MUL   = 5'd8;
  localparam logic [4:0] ST_B_DIV   = 5'd9;
  localparam logic [4:0] ST_B_WAIT  = 5'd10;
  localparam logic [4:0] ST_B_PROD  = 5'd11;
  localparam logic [4:0] ST_B_SUM   = 5'd12;
  localparam logic [4:0] ST_B_CDIV  = 5'd13;
  localparam logic [4:0] ST_B_CWAIT = 5'd14;
  localparam logic [4:0] ST_C_RD    = 5'd15;
  localparam logic [4:0] ST_C_DIV   = 5'd16;
  localparam logic [4:0] ST_C_WAIT  = 5'd17;

  localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(NUM_BINS - 1);

  logic [4:0]        state;
  logic [ADDR_W-1:0] addr;
  logic [ITER_W-1:0] it_cnt;
  logic              use_uniform;
  logic              fresh;
  logic              rd_oob;
  logic [TOT_W-1:0]  total;
  logic [ACC_W-1:0]  acc;
  logic              c_zero;
  logic              c_sat;
  logic              t_zero;
  logic              t_full;

  logic [MEAS_W-1:0] meas [RINGS];
  logic [ITER_W-1:0] iter_cfg;

  logic                     accept;
  logic                     in_oob;
  logic                     load_we;
  logic [RINGS*RESP_W-1:0]  resp_wdata;
  logic [RINGS*RESP_W-1:0]  resp_rdata;
  logic [EFF_W-1:0]         eff_wdata;
  logic [EFF_W-1:0]         eff_rdata;
  logic [PROB_W-1:0]        prior_rdata;
  logic [PROB_W-1:0]        prior_val;
  logic [PROB_W-1:0]        prior_wdata;
  logic                     prior_we;
  logic [CNT_W-1:0]         cause_rdata;
  logic [CNT_W-1:0]         cause_wdata;
  logic                     cause_we;
  logic [ADDR_W-1:0]        raddr;

  lane_ctl_t         lane_ctl;
  logic [RINGS-1:0]  lane_done;
  logic [PROD_W-1:0] lane_prod [RINGS];
  logic [ACC_W-1:0]  acc_next;

  logic              sd_start;
  logic [DIV_W-1:0]  sd_rem;
  logic [DIV_W-1:0]  sd_divisor;
  logic [Q_W-1:0]    sd_shin;
  logic [STEP_W-1:0] sd_steps;
  logic              sd_done;
  logic [Q_W-1:0]    sd_quot;
  logic [TOT_W:0]    total_next;

  // APB registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RINGS; i++) begin
        meas[i] <= '0;
      end
      iter_cfg <= ITER_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_MEAS1: meas[0] <= pwdata;
        REG_MEAS2: meas[1] <= pwdata;
        REG_MEAS3: meas[2] <= pwdata;
        REG_MEAS4: meas[3] <= pwdata;
        REG_ITER:  iter_cfg <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MEAS1: prdata = meas[0];
      REG_MEAS2: prdata = meas[1];
      REG_MEAS3: prdata = meas[2];
      REG_MEAS4: prdata = meas[3];
      REG_ITER:  prdata = PDATA_W'(iter_cfg);
      default:   prdata = '0;
    endcase
  end

  // item side
  assign item_stall = state != ST_IDLE;
  assign accept     = item_valid && !item_stall;
  assign in_oob     = 32'(item.bin_index) >= NUM_BINS;
  assign load_we    = accept && item.command == CMD_LOAD && !in_oob;
  assign resp_wdata = {item.resp_ring4, item.resp_ring3, item.resp_ring2, item.resp_ring1};
  assign eff_wdata  = EFF_W'(item.resp_ring1) + EFF_W'(item.resp_ring2)
                    + EFF_W'(item.resp_ring3) + EFF_W'(item.resp_ring4);
  assign raddr      = addr;
  assign prior_val  = use_uniform ? UNIFORM : prior_rdata;

  ibu_ram #(.WIDTH(RINGS*RESP_W), .DEPTH(NUM_BINS)) u_resp_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (item.bin_index[ADDR_W-1:0]),
    .wdata (resp_wdata),
    .raddr (raddr),
    .rdata (resp_rdata)
  );

  ibu_ram #(.WIDTH(EFF_W), .DEPTH(NUM_BINS)) u_eff_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (item.bin_index[ADDR_W-1:0]),
    .wdata (eff_wdata),
    .raddr (raddr),
    .rdata (eff_rdata)
  );

  ibu_ram #(.WIDTH(PROB_W), .DEPTH(NUM_BINS)) u_prior_ram (
    .clk   (clk),
    .we    (prior_we),
    .waddr (addr),
    .wdata (prior_wdata),
    .raddr (raddr),
    .rdata (prior_rdata)
  );

  ibu_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_cause_ram (
    .clk   (clk),
    .we    (cause_we),
    .waddr (addr),
    .wdata (cause_wdata),
    .raddr (raddr),
    .rdata (cause_rdata)
  );

  // ring lanes
  always_comb begin
    lane_ctl.sum_clr   = state == ST_INIT;
    lane_ctl.sum_add   = state == ST_A_ADD;
    lane_ctl.div_start = state == ST_B_DIV;
    lane_ctl.prod_load = state == ST_B_PROD;
  end

  for (genvar g = 0; g < RINGS; g++) begin : g_lane
    ibu_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (lane_ctl),
      .resp     (resp_rdata[g*RESP_W +: RESP_W]),
      .prior    (prior_val),
      .meas     (meas[g]),
      .div_done (lane_done[g]),
      .prod     (lane_prod[g])
    );
  end

  // merge: combine ring terms, divide by efficiency, normalize
  always_comb begin
    acc_next = '0;
    for (int i = 0; i < RINGS; i++) begin
      acc_next = acc_next + ACC_W'(lane_prod[i]);
    end
  end

  always_comb begin
    sd_start   = 1'b0;
    sd_rem     = DIV_W'(acc[ACC_W-1:Q_W]);
    sd_divisor = DIV_W'({eff_rdata, 8'h00});
    sd_shin    = acc[Q_W-1:0];
    sd_steps   = STEP_W'(CAUSE_STEPS);
    if (state == ST_B_CDIV) begin
      sd_start = 1'b1;
    end else if (state == ST_C_DIV) begin
      sd_start   = 1'b1;
      sd_rem     = DIV_W'(cause_rdata);
      sd_divisor = DIV_W'(total);
      sd_shin    = '0;
      sd_steps   = STEP_W'(FRAC_STEPS);
    end
  end

  ibu_div u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (sd_start),
    .rem_init (sd_rem),
    .divisor  (sd_divisor),
    .shin     (sd_shin),
    .steps    (sd_steps),
    .done     (sd_done),
    .quot     (sd_quot)
  );

  always_comb begin
    if (c_zero) begin
      cause_wdata = '0;
    end else if (c_sat) begin
      cause_wdata = '1;
    end else begin
      cause_wdata = sd_quot;
    end
    if (t_zero) begin
      prior_wdata = '0;
    end else if (t_full) begin
      prior_wdata = ONE_Q24;
    end else begin
      prior_wdata = sd_quot[PROB_W-1:0];
    end
  end

  assign cause_we   = state == ST_B_CWAIT && sd_done;
  assign prior_we   = state == ST_C_WAIT && sd_done;
  assign total_next = {1'b0, total} + (TOT_W+1)'(cause_wdata);

  // payload registers of the merge stage
  always_ff @(posedge clk) begin
    if (state == ST_B_SUM) begin
      acc <= acc_next;
    end
    if (state == ST_B_CDIV) begin
      c_zero <= eff_rdata == '0;
      c_sat  <= (acc >> Q_W) >= ACC_W'({eff_rdata, 8'h00});
    end
    if (state == ST_C_DIV) begin
      t_zero <= total == '0;
      t_full <= TOT_W'(cause_rdata) >= total;
    end
    if (state == ST_INIT) begin
      total <= '0;
    end else if (cause_we) begin
      total <= total_next[TOT_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      addr         <= '0;
      it_cnt       <= '0;
      use_uniform  <= 1'b1;
      fresh        <= 1'b1;
      rd_oob       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_RD_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.command == CMD_READ) begin
              addr   <= item.bin_index[ADDR_W-1:0];
              rd_oob <= in_oob;
              state  <= ST_RD_WAIT;
            end else if (item.last_load) begin
              use_uniform <= 1'b1;
              fresh       <= 1'b1;
              it_cnt      <= '0;
              state       <= (iter_cfg == '0) ? ST_IDLE : ST_INIT;
            end
          end
        end
        ST_RD_WAIT: state <= ST_RD_OUT;
        ST_RD_OUT: begin
          if (!result_valid || !result_stall) begin
            state <= ST_IDLE;
          end
        end
        ST_INIT: begin
          addr  <= '0;
          state <= ST_A_RD;
        end
        ST_A_RD:  state <= ST_A_MUL;
        ST_A_MUL: state <= ST_A_ADD;
        ST_A_ADD: begin
          addr  <= addr + ADDR_W'(1);
          state <= (addr == LAST_BIN) ? ST_B_RD : ST_A_RD;
        end
        ST_B_RD:  state <= ST_B_MUL;
        ST_B_MUL: state <= ST_B_DIV;
        ST_B_DIV: state <= ST_B_WAIT;
        ST_B_WAIT: begin
          if (&lane_done) begin
            state <= ST_B_PROD;
          end
        end
        ST_B_PROD: state <= ST_B_SUM;
        ST_B_SUM:  state <= ST_B_CDIV;
        ST_B_CDIV: state <= ST_B_CWAIT;
        ST_B_CWAIT: begin
          if (sd_done) begin
            addr  <= addr + ADDR_W'(1);
            state <= (addr == LAST_BIN) ? ST_C_RD : ST_B_RD;
          end
        end
        ST_C_RD:  state <= ST_C_DIV;
        ST_C_DIV: state <= ST_C_WAIT;
        ST_C_WAIT: begin
          if (sd_done) begin
            addr <= addr + ADDR_W'(1);
            if (addr == LAST_BIN) begin
              use_uniform <= 1'b0;
              fresh       <= 1'b0;
              it_cnt      <= it_cnt + ITER_W'(1);
              state       <= (it_cnt + ITER_W'(1) == iter_cfg) ? ST_IDLE : ST_INIT;
            end else begin
              state <= ST_C_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD_OUT && (!result_valid || !result_stall)) begin
      result.out_bin <= BIN_W'(addr);
      if (rd_oob) begin
        result.bin_counts      <= '0;
        result.bin_probability <= '0;
      end else if (fresh) begin
        result.bin_counts      <= '0;
        result.bin_probability <= UNIFORM;
      end else begin
        result.bin_counts      <= cause_rdata;
        result.bin_probability <= prior_rdata;
      end
    end
  end

endmodule
